/* hdl/bba_pkg.sv */
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

    localparam int BLK_W     = 32;   // block number width
    localparam int CNT_W     = 13;   // free count and map_bits width
    localparam int STATUS_W  = 2;
    localparam int KIND_W    = 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    // bitmap word layout: 256 bits per memory row, counted in 32-bit chunks
    localparam int WORD_W    = 256;
    localparam int WORD_LW   = 8;
    localparam int CHUNK_W   = 32;
    localparam int CHUNK_CW  = 6;
    localparam int NCHUNK    = WORD_W / CHUNK_W;
    localparam int CSUM_W    = WORD_LW + 1;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_BLOCKS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_BITS   = 1'd1;

    localparam logic [BLK_W-1:0] DATA_START_RST = 32'd0;
    localparam logic [CNT_W-1:0] MAP_BITS_RST   = 13'd4096;
    localparam logic [CNT_W-1:0] FREE_CNT_MAX   = 13'h1FFF;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, clear scan state
        logic rd_en;    // read next bitmap row
        logic commit;   // write back and load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_row; // row being read is the last one
    } t_sts;

endpackage

/* hdl/bba_if.sv */
// Channel interfaces: request, response and configuration write.
interface bba_req_if;
    logic                          valid;
    logic                          ready;
    logic [bba_pkg::KIND_W-1:0]    kind;
    logic [bba_pkg::BLK_W-1:0]     block_number;
    modport source(output valid, kind, block_number, input ready);
    modport sink(input valid, kind, block_number, output ready);
endinterface

interface bba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bba_pkg::STATUS_W-1:0]  status;
    logic [bba_pkg::BLK_W-1:0]     granted_block;
    logic [bba_pkg::CNT_W-1:0]     free_count;
    modport source(output valid, status, granted_block, free_count, input ready);
    modport sink(input valid, status, granted_block, free_count, output ready);
endinterface

interface bba_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bba_pkg::CFG_IDX_W-1:0] index;
    logic [bba_pkg::CFG_DAT_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* hdl/bba_ctrl.sv */
// Allocator controller: sequences load, row scan, pipeline drain and commit.
module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bba_pkg::t_cmd o_cmd,
    input  bba_pkg::t_sts i_sts
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_drain, n_drain;
    logic       r_out_vld, n_out_vld;

    always_comb begin
        o_in_ready    = (r_state == ST_IDLE);
        o_cmd.load    = o_in_ready && i_in_valid;
        o_cmd.rd_en   = (r_state == ST_SCAN);
        o_cmd.commit  = (r_state == ST_COMMIT) && (!r_out_vld || i_out_ready);
        o_out_valid   = r_out_vld;
    end

    always_comb begin
        n_state   = r_state;
        n_drain   = r_drain;
        n_out_vld = r_out_vld;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.last_row) begin
                    n_state = ST_DRAIN;
                    n_drain = 1'b0;
                end
            end
            ST_DRAIN: begin
                // read stage, then search/count stage, then accumulate
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (o_cmd.commit) begin
                    n_state   = ST_IDLE;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_drain   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_drain   <= n_drain;
            r_out_vld <= n_out_vld;
        end
    end

    a_scan_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_sts.last_row) |=> (r_state == ST_DRAIN))
        else $error("scan did not end in drain");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("commit did not raise output valid");

    a_no_commit_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit && r_out_vld) |-> i_out_ready)
        else $error("commit overwrote a pending result");

endmodule

/* hdl/bba_dp.sv */
// Allocator datapath: bitmap memory, row scan pipeline, counters and result registers.
module bba_dp #(
    parameter int MAP_SIZE = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bba_pkg::t_cmd                  i_cmd,
    output bba_pkg::t_sts                  o_sts,
    input  logic                           i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bba_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic [bba_pkg::KIND_W-1:0]     i_kind,
    input  logic [bba_pkg::BLK_W-1:0]      i_block_number,
    output logic [bba_pkg::STATUS_W-1:0]   o_status,
    output logic [bba_pkg::BLK_W-1:0]      o_granted_block,
    output logic [bba_pkg::CNT_W-1:0]      o_free_count
);

    localparam int WW    = bba_pkg::WORD_W;
    localparam int LW    = bba_pkg::WORD_LW;
    localparam int ROWS  = (MAP_SIZE + WW - 1) / WW;
    localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int NW    = $clog2(MAP_SIZE + 1);

    function automatic logic [bba_pkg::CHUNK_CW-1:0] pop_chunk(
        input logic [bba_pkg::CHUNK_W-1:0] v);
        logic [bba_pkg::CHUNK_CW-1:0] c;
        c = '0;
        for (int k = 0; k < bba_pkg::CHUNK_W; k++) begin
            c = c + bba_pkg::CHUNK_CW'(v[k]);
        end
        return c;
    endfunction

    // configuration
    logic [bba_pkg::BLK_W-1:0] r_data_start;
    logic [bba_pkg::CNT_W-1:0] r_map_bits;

    // bitmap storage; a row never written reads as all free
    logic [WW-1:0]   r_mem [ROWS];
    logic [ROWS-1:0] r_row_vld;

    // per-request state
    logic [bba_pkg::KIND_W-1:0] r_kind;
    logic [NW-1:0]              r_n;
    logic                       r_in_range;
    logic [RA_W-1:0]            r_trow;
    logic [LW-1:0]              r_tbit;
    logic                       r_tval;
    logic [WW-1:0]              r_tword;
    logic                       r_found;
    logic [NW-1:0]              r_acc;

    // scan pipeline
    logic [RA_W-1:0]              r_rd_row;
    logic [WW-1:0]                r_rd_data;
    logic                         r_rd_vld;
    logic                         r_p1_en;
    logic [RA_W-1:0]              r_p1_row;
    logic                         r_p2_en;
    logic [bba_pkg::CHUNK_CW-1:0] r_chunk [bba_pkg::NCHUNK];

    logic [31:0]                  n_eff32, off32, n32, nrow32, row32;
    logic [LW-1:0]                nrem;
    logic [WW-1:0]                eff_word, in_mask, free_vec;
    logic [LW-1:0]                enc;
    logic                         any_free;
    logic [bba_pkg::CSUM_W-1:0]   chunk_sum;
    logic                         alloc_ok, free_ok;
    logic [WW-1:0]                bit_mask, new_word;
    logic [NW-1:0]                cnt_after;
    logic [31:0]                  cnt32;

    assign o_sts.last_row = (r_rd_row == RA_W'(ROWS - 1));

    // bits in use, clamped to the map size
    always_comb begin
        n_eff32 = (32'(r_map_bits) > 32'(MAP_SIZE)) ? 32'(MAP_SIZE) : 32'(r_map_bits);
        off32   = i_block_number - r_data_start;
    end

    // search/count stage on the row just read
    always_comb begin
        eff_word = r_rd_vld ? r_rd_data : '0;
        n32      = 32'(r_n);
        nrow32   = n32 >> LW;
        nrem     = n32[LW-1:0];
        row32    = 32'(r_p1_row);
        for (int j = 0; j < WW; j++) begin
            in_mask[j] = (row32 < nrow32) || ((row32 == nrow32) && (LW'(j) < nrem));
        end
        free_vec = ~eff_word & in_mask;
        any_free = |free_vec;
        enc      = '0;
        for (int j = WW - 1; j >= 0; j--) begin
            if (free_vec[j]) begin
                enc = LW'(j);
            end
        end
        chunk_sum = '0;
        for (int c = 0; c < bba_pkg::NCHUNK; c++) begin
            chunk_sum = chunk_sum + bba_pkg::CSUM_W'(r_chunk[c]);
        end
    end

    // commit
    always_comb begin
        alloc_ok  = (r_kind == bba_pkg::KIND_ALLOC) && r_found;
        free_ok   = (r_kind == bba_pkg::KIND_FREE) && r_in_range && r_tval;
        bit_mask  = WW'(1) << r_tbit;
        new_word  = alloc_ok ? (r_tword | bit_mask) : (r_tword & ~bit_mask);
        cnt_after = alloc_ok ? (r_acc - NW'(1)) : (free_ok ? (r_acc + NW'(1)) : r_acc);
        cnt32     = 32'(cnt_after);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start <= bba_pkg::DATA_START_RST;
            r_map_bits   <= bba_pkg::MAP_BITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bba_pkg::CFG_DATA_START: r_data_start <= i_cfg_data;
                bba_pkg::CFG_MAP_BITS:   r_map_bits   <= i_cfg_data[bba_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd_row];
        end
        if (i_cmd.commit && (alloc_ok || free_ok)) begin
            r_mem[r_trow] <= new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_p1_en   <= 1'b0;
            r_p2_en   <= 1'b0;
            r_found   <= 1'b0;
            r_rd_row  <= '0;
        end else begin
            r_p1_en <= i_cmd.rd_en;
            r_p2_en <= r_p1_en;
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_row_vld[r_rd_row];
                r_rd_row <= r_rd_row + RA_W'(1);
            end
            if (i_cmd.load) begin
                r_found  <= 1'b0;
                r_rd_row <= '0;
            end else if (r_p1_en && (r_kind == bba_pkg::KIND_ALLOC) && !r_found && any_free) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit && (alloc_ok || free_ok)) begin
                r_row_vld[r_trow] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_n        <= NW'(n_eff32);
            r_in_range <= (off32 < n_eff32);
            r_trow     <= RA_W'(off32 >> LW);
            r_tbit     <= off32[LW-1:0];
            r_tval     <= 1'b0;
            r_acc      <= '0;
        end else begin
            if (r_p1_en) begin
                if (r_kind == bba_pkg::KIND_ALLOC) begin
                    if (!r_found && any_free) begin
                        r_trow  <= r_p1_row;
                        r_tbit  <= enc;
                        r_tword <= eff_word;
                    end
                end else if (r_p1_row == r_trow) begin
                    r_tword <= eff_word;
                    r_tval  <= eff_word[r_tbit];
                end
            end
            if (r_p2_en) begin
                r_acc <= r_acc + NW'(chunk_sum);
            end
        end
        if (i_cmd.rd_en) begin
            r_p1_row <= r_rd_row;
        end
        for (int c = 0; c < bba_pkg::NCHUNK; c++) begin
            r_chunk[c] <= pop_chunk(free_vec[c*bba_pkg::CHUNK_W +: bba_pkg::CHUNK_W]);
        end
        if (i_cmd.commit) begin
            if (r_kind == bba_pkg::KIND_ALLOC) begin
                o_status <= r_found ? bba_pkg::ST_OK : bba_pkg::ST_OUT_OF_BLOCKS;
            end else if (!r_in_range) begin
                o_status <= bba_pkg::ST_OUT_OF_RANGE;
            end else if (!r_tval) begin
                o_status <= bba_pkg::ST_NOT_ALLOCATED;
            end else begin
                o_status <= bba_pkg::ST_OK;
            end
            o_granted_block <= alloc_ok ? (r_data_start + 32'({r_trow, r_tbit})) : '0;
            o_free_count    <= (cnt32 > 32'(bba_pkg::FREE_CNT_MAX)) ?
                               bba_pkg::FREE_CNT_MAX : cnt32[bba_pkg::CNT_W-1:0];
        end
    end

    a_grant_bit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_kind == bba_pkg::KIND_ALLOC) && r_found) |-> !r_tword[r_tbit])
        else $error("allocating a bit that is already set");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (32'(r_acc) <= 32'(r_n)))
        else $error("free count exceeds bits in use");

    a_full_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_kind == bba_pkg::KIND_ALLOC) && !r_found) |-> (r_acc == '0))
        else $error("out of blocks with free bits counted");

endmodule

/* hdl/bitmap_block_allocator_unit.sv */
// Top level of the first-fit bitmap block allocator.
// Request accept, row scan over ROWS = ceil(MAP_SIZE/256) rows, pipeline drain, commit
//   and response valid; one 256-bit bitmap row is read and searched per cycle.
// A new request is accepted only once the previous one has committed, since every
//   request scans the full bitmap.
// Reset (synchronous, active low): map all free via per-row valid bits, no clearing
//   pass; data_start = 0, map_bits = 4096. Config port is always ready.
module bitmap_block_allocator_unit #(
    parameter int MAP_SIZE = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bba_req_if.sink    i_req,
    bba_cfg_if.sink    i_cfg,
    bba_rsp_if.source  o_rsp
);

    bba_pkg::t_cmd cmd;
    bba_pkg::t_sts sts;
    logic          cfg_we;

    // config writes go straight into the registers, so the port never stalls
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    // Controller: idle -> scan rows -> drain 2-stage pipe -> commit.
    // Commit waits while a previous response is still held in the output register,
    // so a new request may be accepted before the old response is taken.
    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Datapath: every request scans all rows, counting free in-use bits and, for
    // an allocate, finding the lowest free one; the target row is captured and written
    // back at commit on success, together with the response payload.
    bba_dp #(
        .MAP_SIZE (MAP_SIZE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_kind          (i_req.kind),
        .i_block_number  (i_req.block_number),
        .o_status        (o_rsp.status),
        .o_granted_block (o_rsp.granted_block),
        .o_free_count    (o_rsp.free_count)
    );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the first-fit bitmap block allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_SIZE       = 4096;
    // Idle wait after the last response, with margin over the request-to-response latency.
    localparam int SETTLE_CYCLES  = 40;
    // Longest legal quiet stretch is the HOLD_OFF response hold-off.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF       = 300;
    // Span filled by the full-map test; crosses two bitmap row boundaries.
    localparam logic [bba_pkg::CNT_W-1:0] FULL_SPAN = 13'd520;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_OPS      = 40;

    typedef struct packed {
        logic [bba_pkg::STATUS_W-1:0] status;
        logic [bba_pkg::BLK_W-1:0]    granted_block;
        logic [bba_pkg::CNT_W-1:0]    free_count;
    } t_alloc_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bba_req_if req_if();
    bba_rsp_if rsp_if();
    bba_cfg_if cfg_if();

    bitmap_block_allocator_unit #(
        .MAP_SIZE(MAP_SIZE)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .i_cfg  (cfg_if),
        .o_rsp  (rsp_if)
    );

    // Shadow copy of the allocator state.
    logic [MAP_SIZE-1:0]         alloc_map;
    logic [bba_pkg::BLK_W-1:0]   map_start;
    logic [bba_pkg::CNT_W-1:0]   map_bits_reg;
    int unsigned                 map_span;      // bits in use: map_bits clipped to MAP_SIZE
    int unsigned                 free_in_use;   // clear bits below map_span

    t_alloc_result pending_results[$];  // predicted responses, oldest first
    int unsigned   fail_count = 0;
    bit            idle_on = 1'b1;      // random gaps on both channels
    int unsigned   hold_rsp_cycles = 0; // one-shot long hold-off request for the sink

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Re-derive the visible span and its free count after a register change.
    // Bits beyond the span keep their values but drop out of the count.
    function automatic void refresh_span();
        map_span = (int'(map_bits_reg) > MAP_SIZE) ? MAP_SIZE : int'(map_bits_reg);
        free_in_use = 0;
        for (int i = 0; i < map_span; i++) begin
            if (!alloc_map[i]) free_in_use++;
        end
    endfunction

    // Computes the response to one transaction and updates the shadow map.
    function automatic t_alloc_result predict_block_op(
        input logic [bba_pkg::KIND_W-1:0] kind,
        input logic [bba_pkg::BLK_W-1:0]  blk);
        t_alloc_result r;
        logic [bba_pkg::BLK_W-1:0] offset;
        int unsigned idx;
        r.status = bba_pkg::ST_OK;
        r.granted_block = '0;
        if (kind == bba_pkg::KIND_ALLOC) begin
            // first fit: lowest clear bit within the span
            idx = 0;
            while (idx < map_span && alloc_map[idx]) idx++;
            if (idx < map_span) begin
                alloc_map[idx] = 1'b1;
                free_in_use--;
                r.granted_block = map_start + bba_pkg::BLK_W'(idx);   // wraps mod 2^32
            end else begin
                r.status = bba_pkg::ST_OUT_OF_BLOCKS;
            end
        end else begin
            offset = blk - map_start;                                  // wraps mod 2^32
            if (offset >= map_span) begin
                r.status = bba_pkg::ST_OUT_OF_RANGE;
            end else if (!alloc_map[offset]) begin
                r.status = bba_pkg::ST_NOT_ALLOCATED;
            end else begin
                alloc_map[offset] = 1'b0;
                free_in_use++;
            end
        end
        r.free_count = (free_in_use > bba_pkg::FREE_CNT_MAX) ?
                       bba_pkg::FREE_CNT_MAX : bba_pkg::CNT_W'(free_in_use);
        return r;
    endfunction

    // Offset of some used bit inside the span, -1 when none is used.
    function automatic int pick_used_offset();
        int unsigned origin;
        int unsigned pos;
        if (map_span == 0) return -1;
        origin = $urandom_range(0, map_span - 1);
        for (int unsigned k = 0; k < map_span; k++) begin
            pos = (origin + k) % map_span;
            if (alloc_map[pos]) return int'(pos);
        end
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Sends one request; valid stays high into the next call when no gap
    // is drawn so back-to-back transactions never toggle valid in one step.
    task automatic send_request(input logic [bba_pkg::KIND_W-1:0] kind,
                                input logic [bba_pkg::BLK_W-1:0] blk);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.kind         <= kind;
        req_if.block_number <= blk;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pending_results.push_back(predict_block_op(kind, blk));
    endtask

    // Drops the request valid, waits for every outstanding response,
    // then lets the pipeline drain before anything else happens.
    task automatic settle_block();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes data_start then map_bits as two back-to-back transactions.
    task automatic configure(input logic [bba_pkg::BLK_W-1:0] start,
                             input logic [bba_pkg::CNT_W-1:0] span_bits);
        settle_block();
        for (int i = 0; i < 2; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= (i == 0) ? bba_pkg::CFG_DATA_START : bba_pkg::CFG_MAP_BITS;
            cfg_if.data  <= (i == 0) ? start : bba_pkg::CFG_DAT_W'(span_bits);
            do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        end
        cfg_if.valid <= 1'b0;
        map_start    = start;
        map_bits_reg = span_bits;
        refresh_span();
    endtask

    // One random operation: mostly well-formed allocate/free traffic, with
    // double frees and wild block numbers mixed in.
    task automatic random_operation();
        int unsigned roll;
        int used;
        roll = $urandom_range(0, 99);
        used = pick_used_offset();
        if (roll < 50) begin
            send_request(bba_pkg::KIND_ALLOC, $urandom());   // block number is don't-care
        end else if (roll < 85 && used >= 0) begin
            send_request(bba_pkg::KIND_FREE, map_start + bba_pkg::BLK_W'(used));
        end else if (roll < 93 && map_span != 0) begin
            send_request(bba_pkg::KIND_FREE,
                         map_start + bba_pkg::BLK_W'($urandom_range(0, map_span - 1)));
        end else begin
            send_request(bba_pkg::KIND_FREE, $urandom());
        end
    endtask

    // ------------------------------------------------------------------
    // Response checker and sink-side stalls
    // ------------------------------------------------------------------
    initial begin : response_checker
        int unsigned stall;
        t_alloc_result want;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        rsp_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            stall = 0;
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected response transaction: status %0d block %h count %0d",
                           rsp_if.status, rsp_if.granted_block, rsp_if.free_count);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp_if.status);
                        fail_count++;
                    end
                    if (rsp_if.granted_block !== want.granted_block) begin
                        $error("granted_block mismatch: expected %h, actual %h",
                               want.granted_block, rsp_if.granted_block);
                        fail_count++;
                    end
                    if (rsp_if.free_count !== want.free_count) begin
                        $error("free_count mismatch: expected %0d, actual %0d",
                               want.free_count, rsp_if.free_count);
                        fail_count++;
                    end
                end
                if (idle_on) stall = $urandom_range(0, 6);
            end
            // A pending hold-off request overrides the normal draw.
            if (hold_rsp_cycles != 0) begin
                stall = hold_rsp_cycles;
                hold_rsp_cycles = 0;
            end
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no channel moves for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: start 0, full 4096-bit span, everything free.
    task automatic test_reset_defaults();
        send_request(bba_pkg::KIND_ALLOC, '0);              // grants block 0
        send_request(bba_pkg::KIND_FREE, 32'd0);            // ok
        send_request(bba_pkg::KIND_FREE, 32'd0);            // double free
        send_request(bba_pkg::KIND_FREE, 32'd4096);         // first offset past the span
        send_request(bba_pkg::KIND_FREE, 32'hFFFF_FFFF);    // far out of range
        send_request(bba_pkg::KIND_ALLOC, 32'hFFFF_FFFF);   // block number ignored on allocate
    endtask

    // Base near the top of the 32-bit space: offsets wrap.
    task automatic test_address_wrap();
        configure(32'hFFFF_FFFE, 13'd4);
        send_request(bba_pkg::KIND_ALLOC, '0);              // offset 0 -> FFFFFFFE
        send_request(bba_pkg::KIND_ALLOC, '0);              // offset 1 -> FFFFFFFF
        send_request(bba_pkg::KIND_FREE, 32'd0);            // offset 2 via wrap, never allocated
        send_request(bba_pkg::KIND_FREE, 32'hFFFF_FFFD);    // offset wraps to FFFFFFFF
        send_request(bba_pkg::KIND_FREE, 32'hFFFF_FFFE);    // offset 0, set by the first allocate above
    endtask

    // Span edges: single bit, empty span, shrunk map, oversized map_bits.
    task automatic test_map_limits();
        configure(32'd0, 13'd1);
        send_request(bba_pkg::KIND_ALLOC, '0);              // only bit in use
        send_request(bba_pkg::KIND_ALLOC, '0);              // map full
        send_request(bba_pkg::KIND_FREE, 32'd1);            // set bit outside span: out of range
        configure(32'd0, 13'd0);
        send_request(bba_pkg::KIND_ALLOC, '0);              // empty span: out of blocks
        send_request(bba_pkg::KIND_FREE, 32'd0);            // empty span: out of range
        configure(32'd0, bba_pkg::FREE_CNT_MAX);            // clipped to MAP_SIZE
        send_request(bba_pkg::KIND_FREE, 32'd1);            // hidden bit still set, now freed
        send_request(bba_pkg::KIND_ALLOC, '0);
        send_request(bba_pkg::KIND_FREE, 32'd4095);         // last bit, never used
        send_request(bba_pkg::KIND_FREE, 32'd4096);
        configure(32'd0, bba_pkg::MAP_BITS_RST);
        send_request(bba_pkg::KIND_ALLOC, '0);
    endtask

    // Random phases, each with its own register setting and gap mode.
    task automatic test_random_traffic();
        logic [bba_pkg::BLK_W-1:0] start;
        logic [bba_pkg::CNT_W-1:0] span_bits;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       start = '0;
                1:       start = 32'hFFFF_FFFF - $urandom_range(0, 40);
                default: start = $urandom();
            endcase
            case ($urandom_range(0, 7))
                5:       span_bits = bba_pkg::CNT_W'($urandom_range(0, 1));
                6:       span_bits = bba_pkg::MAP_BITS_RST;
                7:       span_bits = bba_pkg::CNT_W'($urandom_range(0, 8191));
                default: span_bits = bba_pkg::CNT_W'($urandom_range(2, 48));
            endcase
            if (phase == 0) start = 32'hFFFF_FFF0;   // base near the top so that grants can wrap
            configure(start, span_bits);
            idle_on = (phase % 3 != 2);
            for (int n = 0; n < PHASE_OPS; n++) random_operation();
        end
        idle_on = 1'b1;
    endtask

    // The sink holds off for a long stretch while requests keep coming,
    // so the block fills and must stall its request channel.
    task automatic test_back_pressure();
        configure(32'h0000_0100, 13'd16);
        idle_on = 1'b0;
        hold_rsp_cycles = HOLD_OFF;
        for (int n = 0; n < 12; n++) random_operation();
        idle_on = 1'b1;
    endtask

    // Multi-row span: allocate every bit, hit out-of-blocks, reuse the top bit.
    task automatic test_full_map();
        logic [bba_pkg::BLK_W-1:0] start;
        start = $urandom();
        configure(start, FULL_SPAN);
        idle_on = 1'b0;
        while (free_in_use != 0) send_request(bba_pkg::KIND_ALLOC, '0);
        send_request(bba_pkg::KIND_ALLOC, '0);               // out of blocks
        send_request(bba_pkg::KIND_FREE,
                     start + bba_pkg::BLK_W'(FULL_SPAN - 13'd1));  // top bit back
        send_request(bba_pkg::KIND_ALLOC, '0);               // regrants the top bit
        for (int n = 0; n < 20; n++) random_operation();
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.kind         <= bba_pkg::KIND_ALLOC;
        req_if.block_number <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= bba_pkg::CFG_DATA_START;
        cfg_if.data         <= '0;
        alloc_map    = '0;
        map_start    = bba_pkg::DATA_START_RST;
        map_bits_reg = bba_pkg::MAP_BITS_RST;
        refresh_span();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_address_wrap();
        test_map_limits();
        test_random_traffic();
        test_back_pressure();
        test_full_map();

        // Drain: every prediction must be matched before the verdict.
        settle_block();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
